>>> hdl/rx_channel_packet_deframer_macros.svh
// ----------------------------------------------------------------------------
// rx channel packet deframer assertion macros
// shared concurrent assertion forms for the deframer checker
// ----------------------------------------------------------------------------
`ifndef RX_CHANNEL_PACKET_DEFRAMER_MACROS_SVH
`define RX_CHANNEL_PACKET_DEFRAMER_MACROS_SVH

// property checked only outside reset
`define RCPD_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("%m: assertion failed");

// property checked on every edge, reset included
`define RCPD_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("%m: assertion failed");

`endif

>>> hdl/rcpd_pkg.sv
// ----------------------------------------------------------------------------
// rcpd_pkg
// types and constants shared by the rx channel packet deframer modules
// ----------------------------------------------------------------------------
package rcpd_pkg;

  localparam int CHAR_W     = 9;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 7;
  localparam int HDR_BYTES  = 3;
  localparam int COUNT_MAX  = 127;
  localparam int DATA_BIT   = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic CMD_CHAR  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [CHAR_W-1:0]  channel;
    logic [COUNT_W-1:0] block_count;
    logic               last;
  } result_t;

  // results of one word: count, then first and second result
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_res_t;

endpackage

>>> hdl/rcpd_parser.sv
// ----------------------------------------------------------------------------
// rcpd_parser
// packet parse state and per-word decisions, up to two results per word
// ----------------------------------------------------------------------------
module rcpd_parser #(
  parameter int BLOCK_BYTES = 128,
  parameter int PACKET_MAX  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       cmd,
  input  logic [rcpd_pkg::CHAR_W-1:0] rx_char,
  output rcpd_pkg::step_res_t        res
);

  localparam int RAW_CAP   = BLOCK_BYTES - rcpd_pkg::HDR_BYTES;
  localparam int BLOCK_CAP = (RAW_CAP > rcpd_pkg::COUNT_MAX) ? rcpd_pkg::COUNT_MAX : RAW_CAP;
  localparam int SUM_W     = $clog2(rcpd_pkg::COUNT_MAX + PACKET_MAX + 1);

  typedef enum logic [1:0] {
    MODE_CHAN = 2'd0,
    MODE_PKT  = 2'd1,
    MODE_DROP = 2'd2
  } mode_t;

  mode_t                             mode_r, mode_nxt;
  logic [rcpd_pkg::CHAR_W-1:0]       chan_r, chan_nxt;
  logic [rcpd_pkg::COUNT_W-1:0]      fill_r, fill_nxt;

  rcpd_pkg::result_t close0, close_ctl, data_res;
  logic [SUM_W-1:0]  fill_sum;
  logic              fill_nz;

  always_comb begin
    fill_nz  = (fill_r != '0);
    fill_sum = SUM_W'(fill_r) + SUM_W'(PACKET_MAX);

    close0             = '0;
    close0.kind        = rcpd_pkg::KIND_END;
    close0.channel     = chan_r;
    close0.block_count = fill_r;

    close_ctl            = close0;
    close_ctl.byte_value = rx_char[rcpd_pkg::BYTE_W-1:0];

    data_res            = '0;
    data_res.kind       = rcpd_pkg::KIND_DATA;
    data_res.byte_value = rx_char[rcpd_pkg::BYTE_W-1:0];
    data_res.channel    = chan_r;

    res      = '0;
    mode_nxt = mode_r;
    chan_nxt = chan_r;
    fill_nxt = fill_r;

    if (cmd == rcpd_pkg::CMD_DRAIN) begin
      if (fill_nz) begin
        res.n    = 2'd1;
        res.r0   = close0;
        fill_nxt = '0;
      end
    end else begin
      case (mode_r)
        MODE_PKT: begin
          if (rx_char == '0) begin
            if (fill_nz && (fill_sum > SUM_W'(BLOCK_CAP))) begin
              res.n    = 2'd1;
              res.r0   = close0;
              fill_nxt = '0;
            end
            mode_nxt = MODE_CHAN;
          end else if (!rx_char[rcpd_pkg::DATA_BIT]) begin
            res.n    = 2'd1;
            res.r0   = close_ctl;
            fill_nxt = '0;
          end else if (fill_r >= rcpd_pkg::COUNT_W'(BLOCK_CAP)) begin
            // full block closes before it takes the byte
            res.n    = 2'd2;
            res.r0   = close0;
            res.r1   = data_res;
            fill_nxt = rcpd_pkg::COUNT_W'(1);
          end else begin
            res.n    = 2'd1;
            res.r0   = data_res;
            fill_nxt = fill_r + rcpd_pkg::COUNT_W'(1);
          end
        end
        MODE_DROP: begin
          if (rx_char == '0) begin
            mode_nxt = MODE_CHAN;
          end
        end
        default: begin
          if (rx_char == '0) begin
            mode_nxt = MODE_DROP;
          end else begin
            if (rx_char != chan_r) begin
              if (fill_nz) begin
                res.n    = 2'd1;
                res.r0   = close0;
                fill_nxt = '0;
              end
              chan_nxt = rx_char;
            end
            mode_nxt = MODE_PKT;
          end
        end
      endcase
    end

    if (res.n == 2'd1) begin
      res.r0.last = 1'b1;
    end
    if (res.n == 2'd2) begin
      res.r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CHAN;
      chan_r <= '0;
      fill_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      chan_r <= chan_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

>>> hdl/rcpd_result_queue.sv
// ----------------------------------------------------------------------------
// rcpd_result_queue
// three-entry shift queue taking up to two results a cycle, giving one
// ----------------------------------------------------------------------------
module rcpd_result_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rcpd_pkg::step_res_t  res,
  output logic                 room,
  output logic                 head_valid,
  output rcpd_pkg::result_t    head,
  input  logic                 pop
);

  localparam int DEPTH = 3;

  rcpd_pkg::result_t q_r   [DEPTH];
  rcpd_pkg::result_t q_nxt [DEPTH];
  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        base;
  logic              do_pop;
  logic [1:0]        n_in;

  assign do_pop     = pop && (cnt_r != 2'd0);
  assign room       = (cnt_r <= 2'd1);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[0];

  always_comb begin
    n_in    = push ? res.n : 2'd0;
    base    = cnt_r - {1'b0, do_pop};
    cnt_nxt = base + n_in;
    for (int i = 0; i < DEPTH; i++) begin
      if (do_pop && (i < DEPTH - 1)) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((n_in != 2'd0) && (2'(i) == base)) begin
        q_nxt[i] = res.r0;
      end
      if ((n_in == 2'd2) && (2'(i) == base + 2'd1)) begin
        q_nxt[i] = res.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

>>> hdl/rx_channel_packet_deframer.sv
// ----------------------------------------------------------------------------
// rx_channel_packet_deframer
// rebuilds channel data blocks from a multiplexed 9-bit link character stream
// ----------------------------------------------------------------------------
// Takes one link character (or a drain event) per word and gives data bytes
// and block-end words with their control code, channel and byte count.
// A word that yields one result or none is taken every cycle while the output
// is not stalled; a word that yields two results holds off the next word,
// since the output port gives one word per cycle. The path from input to output:
// an input register, then the parser into a three-entry result queue whose
// head drives the output. The parser steps only while the queue has room for
// two results; the input register takes a word whenever it is empty or steps.
module rx_channel_packet_deframer #(
  parameter int BLOCK_BYTES = 128,
  parameter int PACKET_MAX  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rcpd_pkg::IN_DATA_W-1:0]   in_tdata,   // rx_char[8:0], zero pad
  input  logic                             in_tuser,   // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rcpd_pkg::OUT_DATA_W-1:0]  out_tdata,  // byte_value, channel, block_count
  output logic                             out_tuser,  // kind
  output logic                             out_tlast
);

  logic                          in_v_r, in_v_nxt;
  logic                          in_cmd_r;
  logic [rcpd_pkg::CHAR_W-1:0]   in_char_r;
  logic                          in_acc;
  logic                          adv;
  logic                          room;
  rcpd_pkg::step_res_t           res;
  rcpd_pkg::result_t             head;

  assign adv       = in_v_r && room;
  assign in_tready = !in_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    if (in_acc) begin
      in_cmd_r  <= in_tuser;
      in_char_r <= in_tdata[rcpd_pkg::CHAR_W-1:0];
    end
  end

  rcpd_parser #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .PACKET_MAX  (PACKET_MAX)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .cmd     (in_cmd_r),
    .rx_char (in_char_r),
    .res     (res)
  );

  rcpd_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (adv),
    .res        (res),
    .room       (room),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tdata = {head.block_count, head.channel, head.byte_value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

>>> hdl/rcpd_checker.sv
// ----------------------------------------------------------------------------
// rcpd_checker
// port-level checks on the rx channel packet deframer
// ----------------------------------------------------------------------------
`include "rx_channel_packet_deframer_macros.svh"

module rcpd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rcpd_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  // a stalled output word holds
  `RCPD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // nothing comes out in the cycle after reset
  `RCPD_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid)

  // a data byte carries no block count
  `RCPD_ASSERT(a_data_count, clk, rst_n, out_tvalid && out_tuser == rcpd_pkg::KIND_DATA |-> out_tdata[23:17] == 7'd0)

  // data bytes only come from a packet on a nonzero channel
  `RCPD_ASSERT(a_data_chan, clk, rst_n, out_tvalid && out_tuser == rcpd_pkg::KIND_DATA |-> out_tdata[16:8] != 9'd0)

endmodule

bind rx_channel_packet_deframer rcpd_checker u_rcpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
